>>> design/prhs_pkg.sv
`timescale 1ns / 1ps

package prhs_pkg;

  localparam int MAX_WIDTH    = 1024;
  localparam int SAMPLE_BITS  = 24;
  localparam int FRAC_BITS    = 16;

  localparam int OUT_BITS     = 40;
  localparam int GW_BITS      = 11;
  localparam int GH_BITS      = 16;
  localparam int SCALE_BITS   = 32;
  localparam int CFG_IDX_BITS = 8;
  localparam int CFG_DAT_BITS = 32;

  localparam logic [GW_BITS-1:0]    GRID_WIDTH_RST  = GW_BITS'(1024);
  localparam logic [GH_BITS-1:0]    GRID_HEIGHT_RST = GH_BITS'(1024);
  localparam logic [SCALE_BITS-1:0] SCALE_RST       = SCALE_BITS'(65536);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_GRID_WIDTH  = CFG_IDX_BITS'(0),
    REG_GRID_HEIGHT = CFG_IDX_BITS'(1),
    REG_SCALE_X     = CFG_IDX_BITS'(2),
    REG_SCALE_Y     = CFG_IDX_BITS'(3)
  } cfg_reg_t;

  typedef struct packed {
    logic interior;
    logic last;
  } cell_flags_t;

endpackage

>>> design/prhs_in_if.sv
`timescale 1ns / 1ps

interface prhs_in_if #(
  parameter int SAMPLE_BITS = prhs_pkg::SAMPLE_BITS
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] u_sample;
  logic signed [SAMPLE_BITS-1:0] v_sample;

  modport source (output valid, output u_sample, output v_sample, input ready);
  modport sink   (input valid, input u_sample, input v_sample, output ready);
endinterface

>>> design/prhs_out_if.sv
`timescale 1ns / 1ps

interface prhs_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [prhs_pkg::OUT_BITS-1:0]  rhs_value;
  logic                                  frame_last;
  logic                                  saturated;

  modport source (output valid, output rhs_value, output frame_last, output saturated,
                  input ready);
  modport sink   (input valid, input rhs_value, input frame_last, input saturated,
                  output ready);
endinterface

>>> design/prhs_cfg_if.sv
`timescale 1ns / 1ps

interface prhs_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [prhs_pkg::CFG_IDX_BITS-1:0] index;
  logic [prhs_pkg::CFG_DAT_BITS-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> design/pressure_rhs_divergence_stencil_core.sv
`timescale 1ns / 1ps
// Each input transfer passes, in order, the input and line store register, the product
// register and the round/saturate output register before its result is valid.
// Throughput: one cell per cycle; the whole pipeline holds while the output
// register is full and not taken.
// Reset (rst_n low, synchronous): pipeline empty, counters at column 0 row 0,
// registers at defaults; the line store is not cleared.

module pressure_rhs_divergence_stencil_core #(
  parameter int MAX_WIDTH   = prhs_pkg::MAX_WIDTH,
  parameter int SAMPLE_BITS = prhs_pkg::SAMPLE_BITS,
  parameter int FRAC_BITS   = prhs_pkg::FRAC_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  prhs_in_if.sink     in_ch,
  prhs_out_if.source  out_ch,
  prhs_cfg_if.sink    cfg_ch
);

  localparam int CW = $clog2(MAX_WIDTH);

  logic                            restart;
  logic [CW-1:0]                   width_m1;
  logic [prhs_pkg::GH_BITS-1:0]    height_m1;
  logic [prhs_pkg::SCALE_BITS-1:0] scale_x;
  logic [prhs_pkg::SCALE_BITS-1:0] scale_y;

  logic                            adv;
  logic                            in_fire;
  logic                            out_valid;
  logic [CW-1:0]                   col;
  logic [prhs_pkg::GH_BITS-1:0]    row;
  prhs_pkg::cell_flags_t           flags;

  logic signed [SAMPLE_BITS-1:0]   prev_u_r;
  logic                            a_vld_r;
  logic signed [SAMPLE_BITS-1:0]   a_u_r;
  logic signed [SAMPLE_BITS-1:0]   a_prev_r;
  logic signed [SAMPLE_BITS-1:0]   a_v_r;
  prhs_pkg::cell_flags_t           a_flags_r;
  logic [SAMPLE_BITS-1:0]          above;

  assign adv         = !out_valid || out_ch.ready;
  assign in_ch.ready = adv;
  assign in_fire     = in_ch.valid && adv;

  prhs_cfg_regs #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_ch    (cfg_ch),
    .restart   (restart),
    .width_m1  (width_m1),
    .height_m1 (height_m1),
    .scale_x   (scale_x),
    .scale_y   (scale_y)
  );

  prhs_raster_ctr #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_ctr (
    .clk       (clk),
    .rst_n     (rst_n),
    .restart   (restart),
    .step      (in_fire),
    .width_m1  (width_m1),
    .height_m1 (height_m1),
    .col       (col),
    .row       (row),
    .flags     (flags)
  );

  prhs_line_store #(
    .MAX_WIDTH   (MAX_WIDTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_line (
    .clk     (clk),
    .en      (in_fire),
    .addr    (col),
    .wr_data (in_ch.v_sample),
    .rd_data (above)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_u_r <= '0;
      a_vld_r  <= 1'b0;
    end else begin
      if (in_fire) begin
        prev_u_r <= in_ch.u_sample;
      end
      if (adv) begin
        a_vld_r <= in_fire;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_u_r     <= in_ch.u_sample;
      a_prev_r  <= prev_u_r;
      a_v_r     <= in_ch.v_sample;
      a_flags_r <= flags;
    end
  end

  prhs_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .a_vld      (a_vld_r),
    .u_cur      (a_u_r),
    .u_prev     (a_prev_r),
    .v_cur      (a_v_r),
    .v_above    ($signed(above)),
    .a_flags    (a_flags_r),
    .scale_x    (scale_x),
    .scale_y    (scale_y),
    .out_valid  (out_valid),
    .rhs_value  (out_ch.rhs_value),
    .frame_last (out_ch.frame_last),
    .saturated  (out_ch.saturated)
  );

  assign out_ch.valid = out_valid;

  a_ctr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (col <= width_m1) && (row <= height_m1))
    else $error("raster counter outside grid");

  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    restart |=> (col == '0) && (row == '0))
    else $error("size write did not restart the frame");

  a_sat_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ch.saturated) |->
      (out_ch.rhs_value == {1'b0, {(prhs_pkg::OUT_BITS-1){1'b1}}}) ||
      (out_ch.rhs_value == {1'b1, {(prhs_pkg::OUT_BITS-1){1'b0}}}))
    else $error("saturated result not at a range limit");

endmodule

>>> design/prhs_cfg_regs.sv
`timescale 1ns / 1ps

module prhs_cfg_regs #(
  parameter int MAX_WIDTH = prhs_pkg::MAX_WIDTH,
  localparam int CW = $clog2(MAX_WIDTH)
) (
  input  logic                                clk,
  input  logic                                rst_n,
  prhs_cfg_if.sink                            cfg_ch,
  output logic                                restart,
  output logic [CW-1:0]                       width_m1,
  output logic [prhs_pkg::GH_BITS-1:0]        height_m1,
  output logic [prhs_pkg::SCALE_BITS-1:0]     scale_x,
  output logic [prhs_pkg::SCALE_BITS-1:0]     scale_y
);

  localparam int EW = (CW + 1 > prhs_pkg::GW_BITS) ? CW + 1 : prhs_pkg::GW_BITS;

  logic [prhs_pkg::GW_BITS-1:0]    grid_width_r;
  logic [prhs_pkg::GH_BITS-1:0]    grid_height_r;
  logic [prhs_pkg::SCALE_BITS-1:0] scale_x_r;
  logic [prhs_pkg::SCALE_BITS-1:0] scale_y_r;
  logic                            cfg_fire;
  logic [EW-1:0]                   gw_ext;
  logic [EW-1:0]                   gw_eff;

  assign cfg_ch.ready = 1'b1;
  assign cfg_fire     = cfg_ch.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= prhs_pkg::GRID_WIDTH_RST;
      grid_height_r <= prhs_pkg::GRID_HEIGHT_RST;
      scale_x_r     <= prhs_pkg::SCALE_RST;
      scale_y_r     <= prhs_pkg::SCALE_RST;
    end else if (cfg_fire) begin
      case (prhs_pkg::cfg_reg_t'(cfg_ch.index))
        prhs_pkg::REG_GRID_WIDTH:  grid_width_r  <= cfg_ch.data[prhs_pkg::GW_BITS-1:0];
        prhs_pkg::REG_GRID_HEIGHT: grid_height_r <= cfg_ch.data[prhs_pkg::GH_BITS-1:0];
        prhs_pkg::REG_SCALE_X:     scale_x_r     <= cfg_ch.data[prhs_pkg::SCALE_BITS-1:0];
        prhs_pkg::REG_SCALE_Y:     scale_y_r     <= cfg_ch.data[prhs_pkg::SCALE_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign restart = cfg_fire &&
                   ((cfg_ch.index == prhs_pkg::REG_GRID_WIDTH) ||
                    (cfg_ch.index == prhs_pkg::REG_GRID_HEIGHT));

  // clamp the size to the supported range
  always_comb begin
    gw_ext = EW'(grid_width_r);
    if (gw_ext < EW'(3)) begin
      gw_eff = EW'(3);
    end else if (gw_ext > EW'(MAX_WIDTH)) begin
      gw_eff = EW'(MAX_WIDTH);
    end else begin
      gw_eff = gw_ext;
    end
    width_m1 = CW'(gw_eff - EW'(1));
    if (grid_height_r < prhs_pkg::GH_BITS'(3)) begin
      height_m1 = prhs_pkg::GH_BITS'(2);
    end else begin
      height_m1 = grid_height_r - prhs_pkg::GH_BITS'(1);
    end
  end

  assign scale_x = scale_x_r;
  assign scale_y = scale_y_r;

endmodule

>>> design/prhs_raster_ctr.sv
`timescale 1ns / 1ps

module prhs_raster_ctr #(
  parameter int MAX_WIDTH = prhs_pkg::MAX_WIDTH,
  localparam int CW = $clog2(MAX_WIDTH)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         restart,
  input  logic                         step,
  input  logic [CW-1:0]                width_m1,
  input  logic [prhs_pkg::GH_BITS-1:0] height_m1,
  output logic [CW-1:0]                col,
  output logic [prhs_pkg::GH_BITS-1:0] row,
  output prhs_pkg::cell_flags_t        flags
);

  logic [CW-1:0]                col_r;
  logic [CW-1:0]                col_nxt;
  logic [prhs_pkg::GH_BITS-1:0] row_r;
  logic [prhs_pkg::GH_BITS-1:0] row_nxt;
  logic                         row_end;
  logic                         col_end;

  assign col_end = (col_r >= width_m1);
  assign row_end = (row_r >= height_m1);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (restart) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (step) begin
      if (col_end) begin
        col_nxt = '0;
        row_nxt = row_end ? '0 : row_r + prhs_pkg::GH_BITS'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  assign col            = col_r;
  assign row            = row_r;
  assign flags.interior = (col_r != '0) && (col_r < width_m1) &&
                          (row_r != '0) && (row_r < height_m1);
  assign flags.last     = col_end && row_end;

endmodule

>>> design/prhs_line_store.sv
`timescale 1ns / 1ps

module prhs_line_store #(
  parameter int MAX_WIDTH   = prhs_pkg::MAX_WIDTH,
  parameter int SAMPLE_BITS = prhs_pkg::SAMPLE_BITS,
  localparam int CW = $clog2(MAX_WIDTH)
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [CW-1:0]          addr,
  input  logic [SAMPLE_BITS-1:0] wr_data,
  output logic [SAMPLE_BITS-1:0] rd_data
);

  logic [SAMPLE_BITS-1:0] mem [MAX_WIDTH];
  logic [SAMPLE_BITS-1:0] rd_data_r;

  // read returns the row above before this row overwrites it
  always_ff @(posedge clk) begin
    if (en) begin
      mem[addr] <= wr_data;
      rd_data_r <= mem[addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> design/prhs_datapath.sv
`timescale 1ns / 1ps

module prhs_datapath #(
  parameter int SAMPLE_BITS = prhs_pkg::SAMPLE_BITS,
  parameter int FRAC_BITS   = prhs_pkg::FRAC_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 adv,
  input  logic                                 a_vld,
  input  logic signed [SAMPLE_BITS-1:0]        u_cur,
  input  logic signed [SAMPLE_BITS-1:0]        u_prev,
  input  logic signed [SAMPLE_BITS-1:0]        v_cur,
  input  logic signed [SAMPLE_BITS-1:0]        v_above,
  input  prhs_pkg::cell_flags_t                a_flags,
  input  logic [prhs_pkg::SCALE_BITS-1:0]      scale_x,
  input  logic [prhs_pkg::SCALE_BITS-1:0]      scale_y,
  output logic                                 out_valid,
  output logic signed [prhs_pkg::OUT_BITS-1:0] rhs_value,
  output logic                                 frame_last,
  output logic                                 saturated
);

  localparam int OB  = prhs_pkg::OUT_BITS;
  localparam int DW  = SAMPLE_BITS + 1;
  localparam int CFW = prhs_pkg::SCALE_BITS + 1;
  localparam int PW  = DW + CFW;
  localparam int SW  = PW + 1;
  localparam int AW  = (SW > FRAC_BITS + OB + 1) ? SW : FRAC_BITS + OB + 1;
  localparam logic signed [AW-1:0] HALF    = AW'((2 ** FRAC_BITS) / 2);
  localparam logic signed [OB-1:0] POS_MAX = {1'b0, {(OB-1){1'b1}}};
  localparam logic signed [OB-1:0] NEG_MIN = {1'b1, {(OB-1){1'b0}}};

  logic signed [DW-1:0]  dx;
  logic signed [DW-1:0]  dy;
  logic signed [CFW-1:0] cx;
  logic signed [CFW-1:0] cy;
  logic signed [PW-1:0]  px_nxt;
  logic signed [PW-1:0]  py_nxt;
  logic signed [PW-1:0]  px_r;
  logic signed [PW-1:0]  py_r;
  logic                  b_vld_r;
  prhs_pkg::cell_flags_t b_flags_r;

  logic signed [AW-1:0]  acc;
  logic signed [AW-1:0]  shifted;
  logic                  sat_pos;
  logic                  sat_neg;
  logic signed [OB-1:0]  rhs_nxt;
  logic                  sat_nxt;

  logic                  out_vld_r;
  logic signed [OB-1:0]  rhs_r;
  logic                  last_r;
  logic                  sat_r;

  // stage B: differences and products
  assign dx     = DW'(u_cur) - DW'(u_prev);
  assign dy     = DW'(v_cur) - DW'(v_above);
  assign cx     = $signed({1'b0, scale_x});
  assign cy     = $signed({1'b0, scale_y});
  assign px_nxt = PW'(dx) * PW'(cx);
  assign py_nxt = PW'(dy) * PW'(cy);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (adv) begin
      b_vld_r <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      px_r      <= px_nxt;
      py_r      <= py_nxt;
      b_flags_r <= a_flags;
    end
  end

  // stage C: sum, round half up, saturate; cells that are not interior give zero
  always_comb begin
    acc     = AW'(px_r) + AW'(py_r) + HALF;
    shifted = acc >>> FRAC_BITS;
    sat_pos = !shifted[AW-1] && (|shifted[AW-2:OB-1]);
    sat_neg = shifted[AW-1] && !(&shifted[AW-2:OB-1]);
    if (!b_flags_r.interior) begin
      rhs_nxt = '0;
      sat_nxt = 1'b0;
    end else if (sat_pos) begin
      rhs_nxt = POS_MAX;
      sat_nxt = 1'b1;
    end else if (sat_neg) begin
      rhs_nxt = NEG_MIN;
      sat_nxt = 1'b1;
    end else begin
      rhs_nxt = shifted[OB-1:0];
      sat_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rhs_r  <= rhs_nxt;
      last_r <= b_flags_r.last;
      sat_r  <= sat_nxt;
    end
  end

  assign out_valid  = out_vld_r;
  assign rhs_value  = rhs_r;
  assign frame_last = last_r;
  assign saturated  = sat_r;

endmodule
